// File: rtl/rvsc_pkg.sv
// shared constants and types of the rv64 subset core step unit
package rvsc_pkg;

    localparam int unsigned DMEM_BYTES_DEF = 4096;

    localparam int unsigned XLEN     = 64;
    localparam int unsigned ILEN     = 32;
    localparam int unsigned NUM_REGS = 32;
    localparam int unsigned REG_AW   = 5;
    localparam int unsigned NUM_BANKS = 8;

    // major opcodes
    localparam logic [6:0] OP_REG    = 7'h33;
    localparam logic [6:0] OP_IMM    = 7'h13;
    localparam logic [6:0] OP_LOAD   = 7'h03;
    localparam logic [6:0] OP_STORE  = 7'h23;
    localparam logic [6:0] OP_LUI    = 7'h37;
    localparam logic [6:0] OP_BRANCH = 7'h63;

    // funct3 codes
    localparam logic [2:0] F3_ADD = 3'd0;
    localparam logic [2:0] F3_SLL = 3'd1;
    localparam logic [2:0] F3_SLT = 3'd2;
    localparam logic [2:0] F3_SRA = 3'd5;
    localparam logic [2:0] F3_AND = 3'd7;
    localparam logic [2:0] F3_B   = 3'd0;
    localparam logic [2:0] F3_W   = 3'd2;
    localparam logic [2:0] F3_D   = 3'd3;
    localparam logic [2:0] F3_BEQ = 3'd0;

    // funct7 codes
    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_ALT  = 7'h20;

    typedef enum logic [1:0] {
        SZ_B,
        SZ_W,
        SZ_D
    } mem_size_t;

endpackage

// File: rtl/rv64_subset_core_step_unit.sv
// rv64 subset core step unit: three-stage pipeline executing one instruction per item
// an accepted item passes stage 1 (execute), stage 2 (load merge), then the output register that drives m_valid
// throughput: one item per cycle, dependent loads included; outside the clearing pass only m_ready low stalls it
// reset (synchronous, aresetn low) clears pc, register file valid bits and pipeline valids
// after reset a clearing pass zeroes data memory one 8-byte row per cycle, with s_ready
// held low until it finishes
module rv64_subset_core_step_unit #(
    parameter int unsigned DMEM_BYTES = rvsc_pkg::DMEM_BYTES_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [rvsc_pkg::ILEN-1:0]  s_instruction_word,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [rvsc_pkg::XLEN-1:0]  m_next_pc,
    output logic                       m_reg_written,
    output logic [rvsc_pkg::REG_AW-1:0] m_dest_reg,
    output logic [rvsc_pkg::XLEN-1:0]  m_reg_value,
    output logic                       m_branch_taken,
    output logic                       m_recognized
);
    import rvsc_pkg::*;

    // data memory is split into eight byte lanes so any 1/4/8-byte access,
    // aligned or not, touches each lane at most once
    localparam int unsigned AW        = $clog2(DMEM_BYTES);
    localparam int unsigned ROW_W     = AW - 3;
    localparam int unsigned BANK_ROWS = DMEM_BYTES / NUM_BANKS;

    // ---------------------------------------------------------------
    // handshake and stage advance
    // ---------------------------------------------------------------
    logic clr_done_reg;
    logic [ROW_W-1:0] clr_row_reg;

    logic s1_valid_reg, s2_valid_reg, m_valid_reg;
    logic out_free, s2_free, s1_free, s2_adv, s1_adv, accept;

    assign out_free = !m_valid_reg || m_ready;
    assign s2_adv   = s2_valid_reg && out_free;
    assign s2_free  = !s2_valid_reg || out_free;
    assign s1_adv   = s1_valid_reg && s2_free;
    assign s1_free  = !s1_valid_reg || s2_free;
    assign s_ready  = s1_free && clr_done_reg;
    assign accept   = s_valid && s_ready;

    // ---------------------------------------------------------------
    // register file: 32 x 64, registered reads at accept, one write port
    // ---------------------------------------------------------------
    logic [XLEN-1:0] rf_mem [NUM_REGS];
    logic [NUM_REGS-1:0] rf_valid_reg;
    logic [XLEN-1:0] rf_a_q_reg, rf_b_q_reg;
    logic rf_a_ok_reg, rf_b_ok_reg;

    // write-back comes from stage 2 as it moves to the output register
    logic wr_en;
    logic [REG_AW-1:0] wr_rd;
    logic [XLEN-1:0] wr_val;

    logic [REG_AW-1:0] in_rs1, in_rs2;
    assign in_rs1 = s_instruction_word[19:15];
    assign in_rs2 = s_instruction_word[24:20];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            rf_mem[wr_rd] <= wr_val;
        end
        if (accept) begin
            rf_a_q_reg <= rf_mem[in_rs1];
            rf_b_q_reg <= rf_mem[in_rs2];
        end
    end

    // stage 1 operand capture: valid bits, and write-through of a write on the same edge
    logic [ILEN-1:0] s1_instr_reg;
    logic fwd_a_v_reg, fwd_b_v_reg;
    logic [XLEN-1:0] fwd_a_reg, fwd_b_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rf_valid_reg <= '0;
            s1_valid_reg <= 1'b0;
            fwd_a_v_reg  <= 1'b0;
            fwd_b_v_reg  <= 1'b0;
        end else begin
            if (wr_en) begin
                rf_valid_reg[wr_rd] <= 1'b1;
            end
            if (accept) begin
                s1_valid_reg <= 1'b1;
                rf_a_ok_reg  <= rf_valid_reg[in_rs1];
                rf_b_ok_reg  <= rf_valid_reg[in_rs2];
                fwd_a_v_reg  <= wr_en && (wr_rd == in_rs1);
                fwd_b_v_reg  <= wr_en && (wr_rd == in_rs2);
                fwd_a_reg    <= wr_val;
                fwd_b_reg    <= wr_val;
                s1_instr_reg <= s_instruction_word;
            end else if (s1_adv) begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // stage 2 registers, declared early for the bypass into stage 1
    // ---------------------------------------------------------------
    logic [XLEN-1:0] s2_next_pc_reg, s2_val_reg;
    logic s2_writes_reg, s2_is_load_reg, s2_taken_reg, s2_known_reg;
    logic [REG_AW-1:0] s2_rd_reg;
    mem_size_t s2_size_reg;
    logic [2:0] s2_addr_lo_reg;
    logic [7:0] dq_reg [NUM_BANKS];
    logic [XLEN-1:0] s2_val_full;

    // ---------------------------------------------------------------
    // stage 1: decode, operands with bypass, execute, address generation
    // ---------------------------------------------------------------
    logic [6:0] s1_op, s1_f7;
    logic [2:0] s1_f3;
    logic [REG_AW-1:0] s1_rd, s1_rs1, s1_rs2;
    logic [XLEN-1:0] a_raw, b_raw, op_a, op_b;
    logic [XLEN-1:0] imm_i, imm_s, imm_b, imm_u, eff_addr;
    logic [XLEN-1:0] pc_reg;

    assign s1_op  = s1_instr_reg[6:0];
    assign s1_rd  = s1_instr_reg[11:7];
    assign s1_f3  = s1_instr_reg[14:12];
    assign s1_rs1 = s1_instr_reg[19:15];
    assign s1_rs2 = s1_instr_reg[24:20];
    assign s1_f7  = s1_instr_reg[31:25];

    // x0 is never written, so it never matches a bypass and its valid bit stays low
    assign a_raw = fwd_a_v_reg ? fwd_a_reg : (rf_a_ok_reg ? rf_a_q_reg : '0);
    assign b_raw = fwd_b_v_reg ? fwd_b_reg : (rf_b_ok_reg ? rf_b_q_reg : '0);
    assign op_a  = (s2_valid_reg && s2_writes_reg && s2_rd_reg == s1_rs1) ? s2_val_full : a_raw;
    assign op_b  = (s2_valid_reg && s2_writes_reg && s2_rd_reg == s1_rs2) ? s2_val_full : b_raw;

    assign imm_i = {{52{s1_instr_reg[31]}}, s1_instr_reg[31:20]};
    assign imm_s = {{52{s1_instr_reg[31]}}, s1_instr_reg[31:25], s1_instr_reg[11:7]};
    assign imm_b = {{51{s1_instr_reg[31]}}, s1_instr_reg[31], s1_instr_reg[7],
                    s1_instr_reg[30:25], s1_instr_reg[11:8], 1'b0};
    assign imm_u = {{32{s1_instr_reg[31]}}, s1_instr_reg[31:12], 12'h000};

    logic ex_known, ex_writes, ex_taken, ex_load, ex_store;
    logic [XLEN-1:0] ex_val, ex_next;
    mem_size_t ex_size;

    assign eff_addr = op_a + (ex_store ? imm_s : imm_i);

    always_comb begin
        ex_known  = 1'b1;
        ex_writes = 1'b0;
        ex_taken  = 1'b0;
        ex_load   = 1'b0;
        ex_store  = 1'b0;
        ex_size   = SZ_D;
        ex_val    = '0;
        ex_next   = pc_reg + XLEN'(4);
        unique case (s1_op)
            OP_REG: begin
                ex_writes = 1'b1;
                unique case ({s1_f7, s1_f3})
                    {F7_BASE, F3_ADD}: ex_val = op_a + op_b;
                    {F7_ALT,  F3_ADD}: ex_val = op_a - op_b;
                    {F7_BASE, F3_AND}: ex_val = op_a & op_b;
                    {F7_BASE, F3_SLT}: ex_val = {{(XLEN-1){1'b0}},
                                                 ($signed(op_a) < $signed(op_b))};
                    {F7_BASE, F3_SLL}: ex_val = op_a << op_b[5:0];
                    {F7_ALT,  F3_SRA}: ex_val = XLEN'($signed(op_a) >>> op_b[5:0]);
                    default: begin
                        ex_known  = 1'b0;
                        ex_writes = 1'b0;
                    end
                endcase
            end
            OP_IMM: begin
                ex_writes = 1'b1;
                unique case (s1_f3)
                    F3_ADD:  ex_val = op_a + imm_i;
                    F3_AND:  ex_val = op_a & imm_i;
                    default: begin
                        ex_known  = 1'b0;
                        ex_writes = 1'b0;
                    end
                endcase
            end
            OP_LOAD: begin
                ex_writes = 1'b1;
                ex_load   = 1'b1;
                unique case (s1_f3)
                    F3_D:    ex_size = SZ_D;
                    F3_W:    ex_size = SZ_W;
                    F3_B:    ex_size = SZ_B;
                    default: begin
                        ex_known  = 1'b0;
                        ex_writes = 1'b0;
                        ex_load   = 1'b0;
                    end
                endcase
            end
            OP_STORE: begin
                ex_store = 1'b1;
                unique case (s1_f3)
                    F3_D:    ex_size = SZ_D;
                    F3_W:    ex_size = SZ_W;
                    F3_B:    ex_size = SZ_B;
                    default: begin
                        ex_known = 1'b0;
                        ex_store = 1'b0;
                    end
                endcase
            end
            OP_LUI: begin
                ex_writes = 1'b1;
                ex_val    = imm_u;
            end
            OP_BRANCH: begin
                if (s1_f3 == F3_BEQ) begin
                    if (op_a == op_b) begin
                        ex_taken = 1'b1;
                        ex_next  = pc_reg + imm_b;
                    end
                end else begin
                    ex_known = 1'b0;
                end
            end
            default: ex_known = 1'b0;
        endcase
        if (s1_rd == '0) begin
            ex_writes = 1'b0;
        end
        if (!ex_writes) begin
            ex_val = '0;
        end
    end

    // ---------------------------------------------------------------
    // data memory lanes: lane k holds bytes whose address is k mod 8
    // ---------------------------------------------------------------
    logic [7:0] dmem [NUM_BANKS][BANK_ROWS];
    logic [ROW_W-1:0] row_a;
    logic [2:0] addr_lo;
    logic [3:0] access_n;
    logic [ROW_W-1:0] bank_row [NUM_BANKS];
    logic [7:0] bank_wd [NUM_BANKS];
    logic [NUM_BANKS-1:0] bank_we;
    logic mem_we, mem_re;

    assign row_a    = eff_addr[AW-1:3];
    assign addr_lo  = eff_addr[2:0];
    assign mem_we   = s1_adv && ex_store;
    assign mem_re   = s1_adv && ex_load;
    assign access_n = (ex_size == SZ_D) ? 4'd8 : ((ex_size == SZ_W) ? 4'd4 : 4'd1);

    always_comb begin
        for (int k = 0; k < NUM_BANKS; k++) begin
            logic [2:0] ofs;
            ofs = 3'(k) - addr_lo;
            // lanes below the start byte belong to the next row, wrapping at the end
            bank_row[k] = row_a + {{(ROW_W-1){1'b0}}, (3'(k) < addr_lo)};
            bank_wd[k]  = op_b[{ofs, 3'b000} +: 8];
            bank_we[k]  = mem_we && ({1'b0, ofs} < access_n);
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < NUM_BANKS; k++) begin
            if (!clr_done_reg) begin
                dmem[k][clr_row_reg] <= '0;
            end else if (bank_we[k]) begin
                dmem[k][bank_row[k]] <= bank_wd[k];
            end
            if (mem_re) begin
                dq_reg[k] <= dmem[k][bank_row[k]];
            end
        end
    end

    // clearing pass after reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_done_reg <= 1'b0;
            clr_row_reg  <= '0;
        end else if (!clr_done_reg) begin
            clr_row_reg <= clr_row_reg + ROW_W'(1);
            if (clr_row_reg == {ROW_W{1'b1}}) begin
                clr_done_reg <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------
    // program counter and stage 2 capture
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg       <= '0;
            s2_valid_reg <= 1'b0;
        end else begin
            if (s1_adv) begin
                pc_reg         <= ex_next;
                s2_valid_reg   <= 1'b1;
                s2_next_pc_reg <= ex_next;
                s2_writes_reg  <= ex_writes;
                s2_rd_reg      <= ex_writes ? s1_rd : '0;
                s2_val_reg     <= ex_val;
                s2_is_load_reg <= ex_load;
                s2_size_reg    <= ex_size;
                s2_addr_lo_reg <= addr_lo;
                s2_taken_reg   <= ex_taken;
                s2_known_reg   <= ex_known;
            end else if (s2_adv) begin
                s2_valid_reg <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // stage 2: little-endian load merge and sign extension
    // ---------------------------------------------------------------
    logic [XLEN-1:0] ld_raw, ld_val;

    always_comb begin
        for (int i = 0; i < NUM_BANKS; i++) begin
            ld_raw[8*i +: 8] = dq_reg[3'(s2_addr_lo_reg + 3'(i))];
        end
        unique case (s2_size_reg)
            SZ_B:    ld_val = {{56{ld_raw[7]}}, ld_raw[7:0]};
            SZ_W:    ld_val = {{32{ld_raw[31]}}, ld_raw[31:0]};
            default: ld_val = ld_raw;
        endcase
    end

    assign s2_val_full = !s2_writes_reg ? '0 : (s2_is_load_reg ? ld_val : s2_val_reg);
    assign wr_en  = s2_adv && s2_writes_reg;
    assign wr_rd  = s2_rd_reg;
    assign wr_val = s2_val_full;

    // ---------------------------------------------------------------
    // output register
    // ---------------------------------------------------------------
    logic [XLEN-1:0] out_next_pc_reg, out_val_reg;
    logic out_written_reg, out_taken_reg, out_known_reg;
    logic [REG_AW-1:0] out_rd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            if (s2_adv) begin
                m_valid_reg     <= 1'b1;
                out_next_pc_reg <= s2_next_pc_reg;
                out_written_reg <= s2_writes_reg;
                out_rd_reg      <= s2_rd_reg;
                out_val_reg     <= s2_val_full;
                out_taken_reg   <= s2_taken_reg;
                out_known_reg   <= s2_known_reg;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_next_pc      = out_next_pc_reg;
    assign m_reg_written  = out_written_reg;
    assign m_dest_reg     = out_rd_reg;
    assign m_reg_value    = out_val_reg;
    assign m_branch_taken = out_taken_reg;
    assign m_recognized   = out_known_reg;

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    a_no_accept_while_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        !clr_done_reg |-> !s_ready)
        else $error("item accepted during memory clearing pass");

    a_pc_moves_with_stage1: assert property (@(posedge aclk) disable iff (!aresetn)
        !s1_adv |=> $stable(pc_reg))
        else $error("pc changed without an instruction leaving stage 1");

    a_no_x0_write: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> wr_rd != '0)
        else $error("register write to x0");

    a_branch_result_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && out_taken_reg |-> out_known_reg && !out_written_reg)
        else $error("taken branch reported as unknown or writing a register");

    a_write_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> out_free && s2_valid_reg)
        else $error("register write without stage 2 moving to output");

endmodule

// File: sim/testbench.sv
// self-checking testbench of the rv64 subset core step unit
`timescale 1ns / 1ps

module testbench;

    import rvsc_pkg::*;

    localparam int unsigned DMEM_BYTES    = DMEM_BYTES_DEF;
    localparam int unsigned RANDOM_ITEMS  = 900;
    // clearing pass after reset plus the longest sender gap and receiver stall, many times over
    localparam int unsigned WATCHDOG_LIMIT = 4000;
    // drain past the pipeline depth, leaving some margin for stray results
    localparam int unsigned DRAIN_CYCLES  = 12;

    // encodings outside the subset, used for the no-op cases
    localparam logic [6:0] OP_CUSTOM = 7'h0B;
    localparam logic [2:0] F3_UNSUP  = 3'd4;
    localparam logic [2:0] F3_BNE    = 3'd1;
    localparam logic [6:0] F7_MUL    = 7'h01;

    typedef struct packed {
        logic [XLEN-1:0]   next_pc;
        logic              reg_written;
        logic [REG_AW-1:0] dest_reg;
        logic [XLEN-1:0]   reg_value;
        logic              branch_taken;
        logic              recognized;
    } step_result_t;

    // receiver stall patterns
    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_PERIODIC,
        RX_BURSTY
    } rx_mode_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [ILEN-1:0]     s_instruction_word = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [XLEN-1:0]     m_next_pc;
    logic                m_reg_written;
    logic [REG_AW-1:0]   m_dest_reg;
    logic [XLEN-1:0]     m_reg_value;
    logic                m_branch_taken;
    logic                m_recognized;

    // instruction words waiting for the driver, and results the core still owes
    logic [ILEN-1:0]     pending_words[$];
    step_result_t        owed_results[$];

    // architectural state mirror
    logic [XLEN-1:0]     arch_pc;
    logic [XLEN-1:0]     arch_regs[NUM_REGS];
    logic [7:0]          arch_dmem[DMEM_BYTES];

    int unsigned         error_count = 0;
    int unsigned         n_results = 0;
    int unsigned         n_loads = 0;
    int unsigned         n_stores = 0;
    int unsigned         n_taken = 0;
    int unsigned         n_noops = 0;
    int unsigned         idle_cycles = 0;

    // sender burst control
    int unsigned         burst_left = 1;
    int unsigned         gap_left = 0;

    // receiver stall control
    rx_mode_t            rx_mode = RX_OPEN;
    int unsigned         rx_mode_left = 0;
    int unsigned         rx_hold_left = 0;
    int unsigned         rx_phase = 0;

    always #10 aclk = ~aclk;

    rv64_subset_core_step_unit #(
        .DMEM_BYTES(DMEM_BYTES)
    ) u_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_instruction_word(s_instruction_word),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_next_pc         (m_next_pc),
        .m_reg_written     (m_reg_written),
        .m_dest_reg        (m_dest_reg),
        .m_reg_value       (m_reg_value),
        .m_branch_taken    (m_branch_taken),
        .m_recognized      (m_recognized)
    );

    // ------------------------------------------------------------------
    // instruction encoders
    // ------------------------------------------------------------------
    function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                          logic [2:0] f3, logic [4:0] rd, logic [6:0] op);
        return {f7, rs2, rs1, f3, rd, op};
    endfunction

    function automatic logic [31:0] enc_i(logic [11:0] imm, logic [4:0] rs1, logic [2:0] f3,
                                          logic [4:0] rd, logic [6:0] op);
        return {imm, rs1, f3, rd, op};
    endfunction

    function automatic logic [31:0] enc_s(logic [11:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                          logic [2:0] f3);
        return {imm[11:5], rs2, rs1, f3, imm[4:0], OP_STORE};
    endfunction

    function automatic logic [31:0] enc_b(logic [12:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                          logic [2:0] f3);
        return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OP_BRANCH};
    endfunction

    function automatic logic [31:0] enc_u(logic [19:0] imm, logic [4:0] rd);
        return {imm, rd, OP_LUI};
    endfunction

    // low registers most of the time so results feed straight into the next item
    function automatic logic [4:0] pick_reg();
        if ($urandom_range(0, 9) < 7)
            return 5'($urandom_range(0, 7));
        return 5'($urandom_range(0, 31));
    endfunction

    function automatic logic [2:0] pick_size();
        case ($urandom_range(0, 2))
            0: return F3_B;
            1: return F3_W;
            default: return F3_D;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // data memory mirror, byte addresses wrap on the store size
    // ------------------------------------------------------------------
    function automatic int unsigned dmem_index(logic [XLEN-1:0] addr);
        return int'(addr % 64'(DMEM_BYTES));
    endfunction

    function automatic logic [XLEN-1:0] dmem_read(logic [XLEN-1:0] addr, int unsigned nbytes);
        logic [XLEN-1:0] v;
        v = '0;
        for (int unsigned i = 0; i < nbytes; i++)
            v[8*i +: 8] = arch_dmem[dmem_index(addr + 64'(i))];
        return v;
    endfunction

    task automatic dmem_write(logic [XLEN-1:0] addr, logic [XLEN-1:0] v, int unsigned nbytes);
        for (int unsigned i = 0; i < nbytes; i++)
            arch_dmem[dmem_index(addr + 64'(i))] = v[8*i +: 8];
    endtask

    // ------------------------------------------------------------------
    // one instruction against the mirror, queue what the core must report
    // ------------------------------------------------------------------
    task automatic execute_word(logic [31:0] w);
        logic [6:0]      opc;
        logic [4:0]      rd;
        logic [2:0]      f3;
        logic [6:0]      f7;
        logic [XLEN-1:0] a;
        logic [XLEN-1:0] b;
        logic [XLEN-1:0] imm_i;
        logic [XLEN-1:0] imm_s;
        logic [XLEN-1:0] imm_b;
        logic [XLEN-1:0] imm_u;
        logic [XLEN-1:0] val;
        logic [XLEN-1:0] next;
        logic            writes;
        logic            known;
        logic            taken;
        step_result_t    r;

        opc   = w[6:0];
        rd    = w[11:7];
        f3    = w[14:12];
        f7    = w[31:25];
        a     = arch_regs[w[19:15]];
        b     = arch_regs[w[24:20]];
        imm_i = {{52{w[31]}}, w[31:20]};
        imm_s = {{52{w[31]}}, w[31:25], w[11:7]};
        imm_b = {{51{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
        imm_u = {{32{w[31]}}, w[31:12], 12'h000};
        next   = arch_pc + 64'd4;
        writes = 1'b0;
        known  = 1'b1;
        taken  = 1'b0;
        val    = '0;

        case (opc)
            OP_REG: begin
                writes = 1'b1;
                if (f3 == F3_ADD && f7 == F7_BASE)      val = a + b;
                else if (f3 == F3_ADD && f7 == F7_ALT)  val = a - b;
                else if (f3 == F3_AND && f7 == F7_BASE) val = a & b;
                else if (f3 == F3_SLT && f7 == F7_BASE) val = {63'd0, $signed(a) < $signed(b)};
                else if (f3 == F3_SLL && f7 == F7_BASE) val = a << b[5:0];
                else if (f3 == F3_SRA && f7 == F7_ALT)  val = $signed(a) >>> b[5:0];
                else begin
                    known  = 1'b0;
                    writes = 1'b0;
                end
            end
            OP_IMM: begin
                writes = 1'b1;
                if (f3 == F3_ADD)      val = a + imm_i;
                else if (f3 == F3_AND) val = a & imm_i;
                else begin
                    known  = 1'b0;
                    writes = 1'b0;
                end
            end
            OP_LOAD: begin
                writes = 1'b1;
                if (f3 == F3_D) val = dmem_read(a + imm_i, 8);
                else if (f3 == F3_W) begin
                    val = dmem_read(a + imm_i, 4);
                    val = {{32{val[31]}}, val[31:0]};
                end else if (f3 == F3_B) begin
                    val = dmem_read(a + imm_i, 1);
                    val = {{56{val[7]}}, val[7:0]};
                end else begin
                    known  = 1'b0;
                    writes = 1'b0;
                end
                if (known) n_loads++;
            end
            OP_STORE: begin
                if (f3 == F3_D)      dmem_write(a + imm_s, b, 8);
                else if (f3 == F3_W) dmem_write(a + imm_s, b, 4);
                else if (f3 == F3_B) dmem_write(a + imm_s, b, 1);
                else known = 1'b0;
                if (known) n_stores++;
            end
            OP_LUI: begin
                writes = 1'b1;
                val    = imm_u;
            end
            OP_BRANCH: begin
                if (f3 == F3_BEQ) begin
                    if (a == b) begin
                        taken = 1'b1;
                        next  = arch_pc + imm_b;
                        n_taken++;
                    end
                end else begin
                    known = 1'b0;
                end
            end
            default: known = 1'b0;
        endcase

        // x0 swallows the result but the item still counts as recognized
        if (rd == 5'd0)
            writes = 1'b0;
        if (writes)
            arch_regs[rd] = val;
        arch_pc = next;
        if (!known) n_noops++;

        r.next_pc      = next;
        r.reg_written  = writes;
        r.dest_reg     = writes ? rd : '0;
        r.reg_value    = writes ? val : '0;
        r.branch_taken = taken;
        r.recognized   = known;
        owed_results.push_back(r);
    endtask

    task automatic report_field(string fname, logic [XLEN-1:0] exp_v, logic [XLEN-1:0] act_v);
        $display("%0t ns: %s mismatch, expected %h, got %h", $time, fname, exp_v, act_v);
        error_count++;
    endtask

    // ------------------------------------------------------------------
    // driver: bursts of items from pending_words, random gaps between
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        logic            nv;
        logic [ILEN-1:0] nw;
        if (!aresetn) begin
            s_valid            <= 1'b0;
            s_instruction_word <= '0;
        end else begin
            nv = s_valid;
            nw = s_instruction_word;
            if (s_valid && s_ready) begin
                nv = 1'b0;
                if (burst_left > 0) burst_left--;
                if (burst_left == 0) begin
                    // now and then a long stretch with no gaps at all
                    if ($urandom_range(0, 7) == 0) begin
                        burst_left = $urandom_range(80, 160);
                        gap_left   = 0;
                    end else begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                    end
                end
            end
            // valid drops only when a gap is due or no word is pending
            if (!nv || (s_valid && s_ready)) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (!nv && pending_words.size() != 0) begin
                    nv = 1'b1;
                    nw = pending_words.pop_front();
                end
            end
            s_valid            <= nv;
            s_instruction_word <= nw;
        end
    end

    // ------------------------------------------------------------------
    // receiver: switches between stall patterns every so often
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        logic nr;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode      = rx_mode_t'($urandom_range(0, 3));
                rx_mode_left = $urandom_range(20, 200);
            end else begin
                rx_mode_left--;
            end
            rx_phase++;
            case (rx_mode)
                RX_OPEN:     nr = 1'b1;
                RX_COIN:     nr = 1'($urandom_range(0, 1));
                RX_PERIODIC: nr = (rx_phase % 3) != 0;
                default: begin
                    if (rx_hold_left > 0) begin
                        rx_hold_left--;
                        nr = 1'b0;
                    end else begin
                        nr = 1'b1;
                        if ($urandom_range(0, 7) == 0)
                            rx_hold_left = $urandom_range(1, 20);
                    end
                end
            endcase
            m_ready <= nr;
        end
    end

    // ------------------------------------------------------------------
    // monitor: mirror every accepted item, check every accepted result
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        step_result_t exp_r;
        if (!aresetn) begin
            arch_pc = '0;
            for (int i = 0; i < NUM_REGS; i++) arch_regs[i] = '0;
            for (int i = 0; i < DMEM_BYTES; i++) arch_dmem[i] = '0;
        end else begin
            if (s_valid && s_ready)
                execute_word(s_instruction_word);
            if (m_valid && m_ready) begin
                n_results++;
                if (owed_results.size() == 0) begin
                    $display("%0t ns: result with nothing owed, expected none, got pc %h",
                             $time, m_next_pc);
                    error_count++;
                end else begin
                    exp_r = owed_results.pop_front();
                    if (m_next_pc !== exp_r.next_pc)
                        report_field("next_pc", exp_r.next_pc, m_next_pc);
                    if (m_reg_written !== exp_r.reg_written)
                        report_field("reg_written", 64'(exp_r.reg_written), 64'(m_reg_written));
                    if (m_dest_reg !== exp_r.dest_reg)
                        report_field("dest_reg", 64'(exp_r.dest_reg), 64'(m_dest_reg));
                    if (m_reg_value !== exp_r.reg_value)
                        report_field("reg_value", exp_r.reg_value, m_reg_value);
                    if (m_branch_taken !== exp_r.branch_taken)
                        report_field("branch_taken", 64'(exp_r.branch_taken),
                                     64'(m_branch_taken));
                    if (m_recognized !== exp_r.recognized)
                        report_field("recognized", 64'(exp_r.recognized), 64'(m_recognized));
                end
            end
        end
    end

    // watchdog: too long with nothing moving on either side
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t ns: no item moved for %0d cycles, %0d results still owed",
                     $time, idle_cycles, owed_results.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        int unsigned     n_directed;
        int unsigned     kind;
        logic [4:0]      base;
        logic [11:0]     off;
        logic [ILEN-1:0] w;

        // directed: field extremes, every operation, x0, wrap and no-op cases
        pending_words.push_back(enc_u(20'hFFFFF, 5'd1));                      // negative lui
        pending_words.push_back(enc_u(20'h7FFFF, 5'd2));                      // largest positive
        pending_words.push_back(enc_i(12'h800, 5'd0, F3_ADD, 5'd3, OP_IMM)); // imm -2048
        pending_words.push_back(enc_i(12'h7FF, 5'd0, F3_ADD, 5'd4, OP_IMM)); // imm 2047
        pending_words.push_back(enc_i(12'd63, 5'd0, F3_ADD, 5'd12, OP_IMM));
        pending_words.push_back(enc_r(F7_BASE, 5'd2, 5'd2, F3_ADD, 5'd5, OP_REG));
        pending_words.push_back(enc_r(F7_ALT, 5'd4, 5'd0, F3_ADD, 5'd6, OP_REG));
        pending_words.push_back(enc_r(F7_BASE, 5'd4, 5'd1, F3_AND, 5'd8, OP_REG));
        pending_words.push_back(enc_r(F7_BASE, 5'd2, 5'd1, F3_SLT, 5'd9, OP_REG));
        pending_words.push_back(enc_r(F7_BASE, 5'd1, 5'd2, F3_SLT, 5'd10, OP_REG));
        pending_words.push_back(enc_r(F7_BASE, 5'd12, 5'd4, F3_SLL, 5'd11, OP_REG));
        pending_words.push_back(enc_r(F7_ALT, 5'd12, 5'd1, F3_SRA, 5'd13, OP_REG));
        pending_words.push_back(enc_r(F7_ALT, 5'd4, 5'd2, F3_SRA, 5'd14, OP_REG));
        pending_words.push_back(enc_i(12'h800, 5'd4, F3_AND, 5'd15, OP_IMM)); // andi negative
        // doubleword at the last byte wraps around to the start of the store
        pending_words.push_back(enc_s(12'hFFF, 5'd6, 5'd0, F3_D));
        pending_words.push_back(enc_i(12'hFFF, 5'd0, F3_D, 5'd17, OP_LOAD));
        pending_words.push_back(enc_s(12'd8, 5'd1, 5'd0, F3_W));
        pending_words.push_back(enc_i(12'd8, 5'd0, F3_W, 5'd18, OP_LOAD));     // sign-extended
        pending_words.push_back(enc_s(12'd5, 5'd13, 5'd0, F3_B));
        pending_words.push_back(enc_i(12'd5, 5'd0, F3_B, 5'd19, OP_LOAD));     // sign-extended
        pending_words.push_back(enc_i(12'd1, 5'd4, F3_ADD, 5'd0, OP_IMM));     // dest x0
        pending_words.push_back(enc_r(F7_BASE, 5'd1, 5'd2, F3_ADD, 5'd7, OP_CUSTOM));
        pending_words.push_back(enc_r(F7_BASE, 5'd1, 5'd2, F3_UNSUP, 5'd7, OP_REG));
        pending_words.push_back(enc_r(F7_MUL, 5'd1, 5'd2, F3_ADD, 5'd7, OP_REG));
        pending_words.push_back(enc_b(13'h1000, 5'd0, 5'd0, F3_BEQ));          // taken, -4096
        pending_words.push_back(enc_b(13'd16, 5'd2, 5'd1, F3_BEQ));            // not taken
        pending_words.push_back(enc_b(13'd8, 5'd0, 5'd0, F3_BNE));             // bne unsupported
        pending_words.push_back(32'hFFFF_FFFF);
        n_directed = pending_words.size();

        // random: mostly well-formed instructions, some noise and broken encodings
        while (pending_words.size() < n_directed + RANDOM_ITEMS) begin
            kind = $urandom_range(0, 99);
            if (kind < 12) begin
                base = pick_reg();
                pending_words.push_back(enc_u(20'($urandom), base));
                pending_words.push_back(enc_i(12'($urandom), base, F3_ADD, base, OP_IMM));
            end else if (kind < 30) begin
                case ($urandom_range(0, 5))
                    0: w = enc_r(F7_BASE, pick_reg(), pick_reg(), F3_ADD, pick_reg(), OP_REG);
                    1: w = enc_r(F7_ALT, pick_reg(), pick_reg(), F3_ADD, pick_reg(), OP_REG);
                    2: w = enc_r(F7_BASE, pick_reg(), pick_reg(), F3_AND, pick_reg(), OP_REG);
                    3: w = enc_r(F7_BASE, pick_reg(), pick_reg(), F3_SLT, pick_reg(), OP_REG);
                    4: w = enc_r(F7_BASE, pick_reg(), pick_reg(), F3_SLL, pick_reg(), OP_REG);
                    default: w = enc_r(F7_ALT, pick_reg(), pick_reg(), F3_SRA, pick_reg(),
                                       OP_REG);
                endcase
                pending_words.push_back(w);
            end else if (kind < 42) begin
                pending_words.push_back(enc_i(12'($urandom), pick_reg(),
                                              $urandom_range(0, 1) ? F3_ADD : F3_AND,
                                              pick_reg(), OP_IMM));
            end else if (kind < 62) begin
                // store then load near the same spot so loads see written bytes
                base = ($urandom_range(0, 4) == 0) ? 5'd0 : pick_reg();
                off  = 12'($urandom);
                pending_words.push_back(enc_s(off, pick_reg(), base, pick_size()));
                pending_words.push_back(enc_i(off + 12'($urandom_range(0, 7)), base,
                                              pick_size(), pick_reg(), OP_LOAD));
            end else if (kind < 75) begin
                base = pick_reg();
                pending_words.push_back(enc_b(13'($urandom), $urandom_range(0, 1) ? base
                                              : pick_reg(), base, F3_BEQ));
            end else if (kind < 88) begin
                pending_words.push_back($urandom);
            end else begin
                // known major opcode with random funct fields, mostly unsupported
                w = $urandom;
                case ($urandom_range(0, 5))
                    0: w[6:0] = OP_REG;
                    1: w[6:0] = OP_IMM;
                    2: w[6:0] = OP_LOAD;
                    3: w[6:0] = OP_STORE;
                    4: w[6:0] = OP_BRANCH;
                    default: w[6:0] = OP_LUI;
                endcase
                pending_words.push_back(w);
            end
        end

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_words.size() != 0 || s_valid)
            @(posedge aclk);
        while (owed_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("ran %0d directed and %0d random instructions, checked %0d results",
                 n_directed, RANDOM_ITEMS, n_results);
        $display("covered %0d loads, %0d stores, %0d taken branches, %0d no-ops, %0d errors",
                 n_loads, n_stores, n_taken, n_noops, error_count);
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
